[hdl/ipid_pkg.sv]
// ----------------------------------------------------------------------------
// ipid_pkg
// Shared types and constants for the incremental PID speed loop.
// ----------------------------------------------------------------------------
package ipid_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_KP    = 3'd0;
  localparam logic [2:0] REG_KI    = 3'd1;
  localparam logic [2:0] REG_KD    = 3'd2;
  localparam logic [2:0] REG_LIMIT = 3'd3;
  localparam logic [2:0] REG_SCALE = 3'd4;

  // register reset values
  localparam logic [15:0] KP_RESET    = 16'd512;
  localparam logic [15:0] KI_RESET    = 16'd333;
  localparam logic [15:0] KD_RESET    = 16'd205;
  localparam logic [14:0] LIMIT_RESET = 15'd1000;
  localparam logic [15:0] SCALE_RESET = 16'd20266;

  // shared multiplier operand select
  localparam logic [1:0] MUL_SPD = 2'd0;  // pulses * speed_scale
  localparam logic [1:0] MUL_P   = 2'd1;  // first difference * kp
  localparam logic [1:0] MUL_I   = 2'd2;  // error * ki
  localparam logic [1:0] MUL_D   = 2'd3;  // second difference * kd

  // controller to datapath commands
  typedef struct packed {
    logic       load_in;    // capture input request
    logic       mul_en;     // register multiplier product
    logic [1:0] mul_sel;    // multiplier operand pair
    logic       calc_err;   // form speed error
    logic       calc_diff;  // form first and second differences
    logic       clr_sum;    // clear increment accumulator
    logic       add_sum;    // add product to increment accumulator
    logic       calc_acc;   // add scaled increment to drive
    logic       commit;     // clamp, update state, load output
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;         // output register can take a result this cycle
  } sts_t;

endpackage

[hdl/incremental_pid_speed_loop_core.sv]
// ----------------------------------------------------------------------------
// incremental_pid_speed_loop_core
// Velocity-form PID speed loop for one wheel, one request per control tick.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (in_*): one request per control tick carrying the target
//   speed and the signed encoder pulse count since the last tick.
//   Output stream (out_*): one result per request with the clamped drive
//   value and the speed error in tdata, and the saturation flag in tuser.
//   Config port (cfg_*): single-cycle writes of the gains, the drive limit
//   and the pulse-to-speed scale; write only while no request is in flight.
// Timing:
//   A request is taken in the idle state; its result shows on out_tvalid
//   after the multiply, add and clamp steps. The next request is taken only
//   once that result is registered, so one request is in flight at a time.
//   The throughput is set by the single shared multiplier, used in turn for
//   the speed scale and the three gain products, plus the add and clamp steps.
// Reset:
//   rst_n (synchronous) restores the register defaults and clears the error
//   history and the drive accumulator; no result is pending afterwards.
// Stall:
//   A result waits in the output register while out_tready is low; a newer
//   request finishes its arithmetic and holds until that register frees up.
// ----------------------------------------------------------------------------
module incremental_pid_speed_loop_core (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] target_speed, [31:16] encoder_pulses
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [15:0] drive_value, [32:16] speed_error, zero pad
  output logic        out_tuser,  // [0] saturated
  // configuration writes
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import ipid_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic [15:0] drive_value;
  logic [16:0] speed_error;

  // sequencer: walks each request through the multiply and accumulate steps
  ipid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic, gain registers, error history and output register
  ipid_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .target_speed   (in_tdata[15:0]),
    .encoder_pulses (in_tdata[31:16]),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .drive_value    (drive_value),
    .speed_error    (speed_error),
    .saturated      (out_tuser)
  );

  assign out_tdata = {7'd0, speed_error, drive_value};

endmodule

[hdl/ipid_ctrl.sv]
// ----------------------------------------------------------------------------
// ipid_ctrl
// Sequencer for one control tick: multiply steps over a shared multiplier.
// ----------------------------------------------------------------------------
module ipid_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ipid_pkg::sts_t sts,
  output ipid_pkg::cmd_t cmd
);
  import ipid_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SPD  = 4'd1;
  localparam logic [3:0] ST_ERR  = 4'd2;
  localparam logic [3:0] ST_DIFF = 4'd3;
  localparam logic [3:0] ST_MP   = 4'd4;
  localparam logic [3:0] ST_MI   = 4'd5;
  localparam logic [3:0] ST_MD   = 4'd6;
  localparam logic [3:0] ST_AD   = 4'd7;
  localparam logic [3:0] ST_ACC  = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_SPD;
        end
      end
      ST_SPD: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SPD;
        state_nxt   = ST_ERR;
      end
      ST_ERR: begin
        cmd.calc_err = 1'b1;
        state_nxt    = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.calc_diff = 1'b1;
        cmd.clr_sum   = 1'b1;
        state_nxt     = ST_MP;
      end
      ST_MP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_P;
        state_nxt   = ST_MI;
      end
      ST_MI: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_I;
        cmd.add_sum = 1'b1;
        state_nxt   = ST_MD;
      end
      ST_MD: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_D;
        cmd.add_sum = 1'b1;
        state_nxt   = ST_AD;
      end
      ST_AD: begin
        cmd.add_sum = 1'b1;
        state_nxt   = ST_ACC;
      end
      ST_ACC: begin
        cmd.calc_acc = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        // hold here while the previous result is still waiting
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/ipid_dp.sv]
// ----------------------------------------------------------------------------
// ipid_dp
// Datapath: gain registers, shared multiplier, error history, clamp, output.
// ----------------------------------------------------------------------------
module ipid_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_wr_en,
  input  logic [2:0]     cfg_addr,
  input  logic [15:0]    cfg_wdata,
  input  logic [15:0]    target_speed,
  input  logic [15:0]    encoder_pulses,
  input  ipid_pkg::cmd_t cmd,
  output ipid_pkg::sts_t sts,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [15:0]    drive_value,
  output logic [16:0]    speed_error,
  output logic           saturated
);
  import ipid_pkg::*;

  // configuration
  logic [15:0] kp_r, ki_r, kd_r, scale_r;
  logic [14:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r    <= KP_RESET;
      ki_r    <= KI_RESET;
      kd_r    <= KD_RESET;
      limit_r <= LIMIT_RESET;
      scale_r <= SCALE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_KP:    kp_r    <= cfg_wdata;
        REG_KI:    ki_r    <= cfg_wdata;
        REG_KD:    kd_r    <= cfg_wdata;
        REG_LIMIT: limit_r <= cfg_wdata[14:0];
        REG_SCALE: scale_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // working registers (payload, no reset)
  logic signed [15:0] target_r;
  logic signed [15:0] pulses_r;
  logic signed [35:0] prod_r;
  logic signed [16:0] err_r;
  logic signed [17:0] d1_r;
  logic signed [18:0] d2_r;
  logic signed [37:0] sum_r;
  logic signed [30:0] accsum_r;

  // tick history (control state)
  logic signed [17:0] e1_r, e2_r;
  logic signed [15:0] drv_r;

  // output register
  logic               out_valid_r;
  logic [15:0]        out_drive_r;
  logic [16:0]        out_err_r;
  logic               out_sat_r;

  // shared multiplier: 19-bit signed by 17-bit signed (gain zero extended)
  logic signed [18:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [35:0] mul_p;

  always_comb begin
    case (cmd.mul_sel)
      MUL_SPD: begin
        mul_a = {{3{pulses_r[15]}}, pulses_r};
        mul_b = $signed({1'b0, scale_r});
      end
      MUL_P: begin
        mul_a = {d1_r[17], d1_r};
        mul_b = $signed({1'b0, kp_r});
      end
      MUL_I: begin
        mul_a = {{2{err_r[16]}}, err_r};
        mul_b = $signed({1'b0, ki_r});
      end
      MUL_D: begin
        mul_a = d2_r;
        mul_b = $signed({1'b0, kd_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // measured speed: product / 65536, toward zero
  logic signed [19:0] meas_c;
  logic signed [16:0] err_c;
  assign meas_c = prod_r[35:16] + 20'((prod_r[35] && (prod_r[15:0] != '0)) ? 1 : 0);
  assign err_c  = {target_r[15], target_r} - meas_c[16:0];

  // differences
  logic signed [17:0] d1_c;
  logic signed [18:0] d2_c;
  assign d1_c = {err_r[16], err_r} - e1_r;
  assign d2_c = {{2{err_r[16]}}, err_r} - {e1_r, 1'b0} + {e2_r[17], e2_r};

  // increment: sum / 256, toward zero
  logic signed [29:0] inc_c;
  logic signed [30:0] accsum_c;
  assign inc_c    = sum_r[37:8] + 30'((sum_r[37] && (sum_r[7:0] != '0)) ? 1 : 0);
  assign accsum_c = {{15{drv_r[15]}}, drv_r} + {inc_c[29], inc_c};

  // clamp to +-limit
  logic signed [30:0] lim_pos, lim_neg;
  logic signed [15:0] clamp_c;
  logic               sat_c;
  assign lim_pos = $signed({16'd0, limit_r});
  assign lim_neg = -lim_pos;

  always_comb begin
    clamp_c = accsum_r[15:0];
    sat_c   = 1'b0;
    if (accsum_r > lim_pos) begin
      clamp_c = lim_pos[15:0];
      sat_c   = 1'b1;
    end else if (accsum_r < lim_neg) begin
      clamp_c = lim_neg[15:0];
      sat_c   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      target_r <= target_speed;
      pulses_r <= encoder_pulses;
    end
    if (cmd.mul_en)    prod_r   <= mul_p;
    if (cmd.calc_err)  err_r    <= err_c;
    if (cmd.calc_diff) begin
      d1_r <= d1_c;
      d2_r <= d2_c;
    end
    if (cmd.clr_sum) begin
      sum_r <= '0;
    end else if (cmd.add_sum) begin
      sum_r <= sum_r + {{2{prod_r[35]}}, prod_r};
    end
    if (cmd.calc_acc)  accsum_r <= accsum_c;
    if (cmd.commit) begin
      out_drive_r <= clamp_c;
      out_err_r   <= err_r;
      out_sat_r   <= sat_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_r        <= '0;
      e2_r        <= '0;
      drv_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        e2_r  <= e1_r;
        e1_r  <= {err_r[16], err_r};
        drv_r <= clamp_c;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign drive_value  = out_drive_r;
  assign speed_error  = out_err_r;
  assign saturated    = out_sat_r;

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the incremental PID speed loop core. A directed
// table covers reset state, field extremes, register edge cases and the clamp
// boundary, then random requests run under three idle profiles with
// frequent gain/limit/scale changes, all scored against a local predictor.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ipid_pkg::*;

  // indexes past the last register; writes there must be dropped
  localparam logic [2:0] REG_SPARE_A = 3'd5;
  localparam logic [2:0] REG_SPARE_B = 3'd6;
  localparam logic [2:0] REG_SPARE_C = 3'd7;

  // run length: 27 settings x 30 random requests plus the directed table;
  // the cycle ceiling is several times the slowest legal run
  localparam int SEGMENTS_PER_PHASE = 9;
  localparam int REQS_PER_SEGMENT   = 30;
  localparam int TAIL_CYCLES        = 20;
  localparam int CYCLE_LIMIT        = 250000;

  typedef struct packed {
    logic signed [15:0] drive;
    logic signed [16:0] err;
    logic               sat;
  } drive_result_t;

  typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [2:0]         addr;
    logic [15:0]        wdata;
    logic signed [15:0] tgt;
    logic signed [15:0] pls;
    logic               typed;   // expected result written out in the row
    drive_result_t      result;
  } dir_row_t;

  localparam drive_result_t NO_RESULT = '0;
  localparam int DIRECTED_COUNT = 31;

  // Directed table. Typed results: reset state, full-scale error under the
  // default gains, and the clamp boundary with kp=kd=0, ki=1.0, scale=0 so
  // that every request adds its target straight onto the drive.
  localparam dir_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{ROW_REQ, REG_KP, 16'h0000, 16'sd0, 16'sd0, 1'b1, '{16'sd0, 17'sd0, 1'b0}},
    '{ROW_REQ, REG_KP, 16'h0000, 16'sh7FFF, 16'sh8000, 1'b1,
      '{16'sd1000, 17'sd42900, 1'b1}},
    '{ROW_REQ, REG_KP, 16'h0000, 16'sh8000, 16'sh7FFF, 1'b1,
      '{-16'sd1000, -17'sd42900, 1'b1}},
    '{ROW_REQ, REG_KP, 16'h0000, 16'sd100, 16'sd50, 1'b0, NO_RESULT},
    '{ROW_REQ, REG_KP, 16'h0000, -16'sd250, -16'sd300, 1'b0, NO_RESULT},
    '{ROW_REQ, REG_KP, 16'h0000, 16'sd7, 16'sd1, 1'b0, NO_RESULT},
    // limit write with bit 15 set: the extra bit drops, limit becomes zero
    '{ROW_CFG, REG_LIMIT, 16'h8000, 16'sd0, 16'sd0, 1'b0, NO_RESULT},
    '{ROW_REQ, REG_KP, 16'h0000, 16'sd500, 16'sd0, 1'b0, NO_RESULT},
    '{ROW_REQ, REG_KP, 16'h0000, 16'sd0, 16'sd0, 1'b0, NO_RESULT},
    // writes to unmapped indexes change nothing
    '{ROW_CFG, REG_SPARE_A, 16'hFFFF, 16'sd0, 16'sd0, 1'b0, NO_RESULT},
    '{ROW_CFG, REG_SPARE_B, 16'hFFFF, 16'sd0, 16'sd0, 1'b0, NO_RESULT},
    '{ROW_CFG, REG_SPARE_C, 16'hFFFF, 16'sd0, 16'sd0, 1'b0, NO_RESULT},
    '{ROW_REQ, REG_KP, 16'h0000, -16'sd123, 16'sd456, 1'b0, NO_RESULT},
    '{ROW_CFG, REG_KP, 16'h0000, 16'sd0, 16'sd0, 1'b0, NO_RESULT},
    '{ROW_CFG, REG_KI, 16'h0100, 16'sd0, 16'sd0, 1'b0, NO_RESULT},
    '{ROW_CFG, REG_KD, 16'h0000, 16'sd0, 16'sd0, 1'b0, NO_RESULT},
    '{ROW_CFG, REG_SCALE, 16'h0000, 16'sd0, 16'sd0, 1'b0, NO_RESULT},
    '{ROW_CFG, REG_LIMIT, 16'd1000, 16'sd0, 16'sd0, 1'b0, NO_RESULT},
    // drive starts at zero (zero limit above forced it); hit +limit exactly
    '{ROW_REQ, REG_KP, 16'h0000, 16'sd1000, 16'sd12345, 1'b1,
      '{16'sd1000, 17'sd1000, 1'b0}},
    '{ROW_REQ, REG_KP, 16'h0000, 16'sd1, -16'sd9, 1'b1,
      '{16'sd1000, 17'sd1, 1'b1}},
    '{ROW_REQ, REG_KP, 16'h0000, -16'sd2000, 16'sh7FFF, 1'b1,
      '{-16'sd1000, -17'sd2000, 1'b0}},
    '{ROW_REQ, REG_KP, 16'h0000, -16'sd1, 16'sh8000, 1'b1,
      '{-16'sd1000, -17'sd1, 1'b1}},
    // all registers at their maximum
    '{ROW_CFG, REG_KP, 16'hFFFF, 16'sd0, 16'sd0, 1'b0, NO_RESULT},
    '{ROW_CFG, REG_KI, 16'hFFFF, 16'sd0, 16'sd0, 1'b0, NO_RESULT},
    '{ROW_CFG, REG_KD, 16'hFFFF, 16'sd0, 16'sd0, 1'b0, NO_RESULT},
    '{ROW_CFG, REG_SCALE, 16'hFFFF, 16'sd0, 16'sd0, 1'b0, NO_RESULT},
    '{ROW_CFG, REG_LIMIT, 16'h7FFF, 16'sd0, 16'sd0, 1'b0, NO_RESULT},
    '{ROW_REQ, REG_KP, 16'h0000, 16'sh7FFF, 16'sh8000, 1'b0, NO_RESULT},
    '{ROW_REQ, REG_KP, 16'h0000, 16'sh8000, 16'sh7FFF, 1'b0, NO_RESULT},
    '{ROW_REQ, REG_KP, 16'h0000, 16'sh8000, 16'sh8000, 1'b0, NO_RESULT},
    '{ROW_REQ, REG_KP, 16'h0000, 16'sh7FFF, 16'sh7FFF, 1'b0, NO_RESULT}
  };

  // DUT ports; every input starts at a known value
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [15:0] target_speed, [31:16] encoder_pulses
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // [15:0] drive_value, [32:16] speed_error, pad
  logic        out_tuser;       // [0] saturated
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;

  // predictor copy of the registers and the loop state
  logic [15:0]        kp_q8     = KP_RESET;
  logic [15:0]        ki_q8     = KI_RESET;
  logic [15:0]        kd_q8     = KD_RESET;
  logic [14:0]        limit_mag = LIMIT_RESET;
  logic [15:0]        scale_q16 = SCALE_RESET;
  logic signed [17:0] err_prev  = '0;
  logic signed [17:0] err_older = '0;
  logic signed [15:0] drive_acc = '0;

  drive_result_t pending_drive_q [$];

  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int error_count = 0;
  int request_count = 0;
  int result_count = 0;
  int setting_count = 0;
  int cycle_count = 0;

  incremental_pid_speed_loop_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // One control tick: scale pulses, form error, add the velocity-form
  // increment (full precision, truncated toward zero), clamp, update history.
  function automatic drive_result_t speed_loop_step(logic signed [15:0] tgt,
                                                    logic signed [15:0] pls);
    longint measured;
    longint err;
    longint e1;
    longint e2;
    longint lim;
    longint incr;
    longint total;
    drive_result_t res;
    measured = (longint'(pls) * longint'(scale_q16)) / 65536;
    err = longint'(tgt) - measured;
    e1 = longint'(err_prev);
    e2 = longint'(err_older);
    lim = longint'(limit_mag);
    incr = (longint'(kp_q8) * (err - e1) + longint'(ki_q8) * err
            + longint'(kd_q8) * (err - 2 * e1 + e2)) / 256;
    total = longint'(drive_acc) + incr;
    res.sat = 1'b0;
    // a sum sitting exactly on the limit is not a clamp
    if (total > lim) begin
      total = lim;
      res.sat = 1'b1;
    end
    if (total < -lim) begin
      total = -lim;
      res.sat = 1'b1;
    end
    err_older = err_prev;
    err_prev = err[17:0];
    drive_acc = total[15:0];
    res.drive = total[15:0];
    res.err = err[16:0];
    return res;
  endfunction

  // Offer one request with optional sender idle cycles ahead of it; predict
  // on acceptance. tvalid stays high on return so back-to-back requests
  // never toggle it within one step.
  task automatic send_request(input logic signed [15:0] tgt,
                              input logic signed [15:0] pls,
                              input logic typed, input drive_result_t typed_result);
    drive_result_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {pls, tgt};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = speed_loop_step(tgt, pls);
    pending_drive_q.push_back(typed ? typed_result : predicted);
    request_count++;
  endtask

  // Drop tvalid and hold off until every outstanding result has drained.
  task automatic wait_drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_drive_q.size() != 0) @(negedge clk);
  endtask

  // Single-cycle register write; caller guarantees the core is idle.
  task automatic cfg_write(input logic [2:0] addr, input logic [15:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    case (addr)
      REG_KP:    kp_q8 = data;
      REG_KI:    ki_q8 = data;
      REG_KD:    kd_q8 = data;
      REG_LIMIT: limit_mag = data[14:0];
      REG_SCALE: scale_q16 = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // gains and scale: zero, full scale, near-nominal, or anything
  function automatic logic [15:0] pick_operand();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3, 4: return 16'($urandom_range(1024));
      default: return 16'($urandom);
    endcase
  endfunction

  // speeds and pulse counts: extremes, full range, or around zero
  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2, 3:    return 16'($urandom);
      default: return 16'($urandom_range(400) - 200);
    endcase
  endfunction

  // receiver backpressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // scoreboard: every accepted result against the oldest prediction
  always @(posedge clk) begin : result_check
    drive_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_drive_q.size() == 0) begin
        error_count++;
        $display("%0t: result with nothing pending, expected none, actual %h",
                 $time, out_tdata);
      end else begin
        want = pending_drive_q.pop_front();
        result_count++;
        if (out_tdata[15:0] !== want.drive) begin
          error_count++;
          $display("%0t: drive_value expected %0d actual %0d", $time,
                   want.drive, $signed(out_tdata[15:0]));
        end
        if (out_tdata[32:16] !== want.err) begin
          error_count++;
          $display("%0t: speed_error expected %0d actual %0d", $time,
                   want.err, $signed(out_tdata[32:16]));
        end
        if (out_tuser !== want.sat) begin
          error_count++;
          $display("%0t: saturated expected %0b actual %0b", $time,
                   want.sat, out_tuser);
        end
        if (out_tdata[39:33] !== '0) begin
          error_count++;
          $display("%0t: tdata pad expected 0 actual %h", $time, out_tdata[39:33]);
        end
      end
    end
  end

  // hard ceiling on run length
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results still pending",
               $time, cycle_count, pending_drive_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [15:0] limit_word;
    // sync reset, held low from time zero and released on a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    src_idle_pct = 18;
    sink_idle_pct = 52;

    // directed table; register rows only once the core has drained
    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      if (DIRECTED_ROWS[i].kind == ROW_CFG) begin
        wait_drain();
        cfg_write(DIRECTED_ROWS[i].addr, DIRECTED_ROWS[i].wdata);
      end else begin
        send_request(DIRECTED_ROWS[i].tgt, DIRECTED_ROWS[i].pls,
                     DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].result);
      end
    end

    // random part: receiver-heavy idling, sender-heavy, then none
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 18;
          sink_idle_pct = 52;
        end
        1: begin
          src_idle_pct = 52;
          sink_idle_pct = 18;
        end
        default: begin
          src_idle_pct = 0;
          sink_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < SEGMENTS_PER_PHASE; seg++) begin
        // new setting for every segment; upper data bits stay random so the
        // limit register sees its dropped bit too
        wait_drain();
        cfg_write(REG_KP, pick_operand());
        cfg_write(REG_KI, pick_operand());
        cfg_write(REG_KD, pick_operand());
        cfg_write(REG_SCALE, pick_operand());
        case ($urandom_range(5))
          0:       limit_word = 16'($urandom_range(1)) << 15;
          1:       limit_word = 16'h7FFF | (16'($urandom_range(1)) << 15);
          2, 3:    limit_word = 16'($urandom_range(2000));
          default: limit_word = 16'($urandom);
        endcase
        cfg_write(REG_LIMIT, limit_word);
        if ($urandom_range(3) == 0)
          cfg_write(3'($urandom_range(7, 5)), 16'($urandom));
        setting_count++;
        for (int k = 0; k < REQS_PER_SEGMENT; k++) begin
          // now and then let the pipe run dry before the next request
          if ($urandom_range(59) == 0)
            wait_drain();
          send_request(pick_value(), pick_value(), 1'b0, NO_RESULT);
        end
      end
    end

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Summary: %0d requests, %0d results scored, %0d random settings",
             request_count, result_count, setting_count);
    $display("  plus directed extremes, zero limit, clamp edge, unmapped writes");
    if (error_count == 0 && pending_drive_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[incremental_pid_speed_loop_core.f]
hdl/ipid_pkg.sv
hdl/ipid_ctrl.sv
hdl/ipid_dp.sv
hdl/incremental_pid_speed_loop_core.sv
tb/sv/testbench.sv
